[sv/compacting_list_store_defines.svh]
// ----------------------------------------------------------------------------
// compacting_list_store_defines.svh
// Assertion macros used by the list store top level.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_LIST_STORE_DEFINES_SVH
`define COMPACTING_LIST_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define CLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define CLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cls_pkg.sv]
// ----------------------------------------------------------------------------
// cls_pkg
// Types and codes shared by the list store top level and its cells.
// ----------------------------------------------------------------------------
package cls_pkg;

  // Request codes; the fourth code is a no-operation.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2
  } cls_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_COMMIT
  } cls_state_t;

  // Input word.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] item_key;
  } cls_in_t;

  // Result word.
  typedef struct packed {
    logic       hit;
    logic       full_reject;
    logic [4:0] entry_count;
  } cls_out_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic add_en;
    logic rm_en;
  } cls_ctrl_t;

endpackage

[sv/compacting_list_store.sv]
// ----------------------------------------------------------------------------
// compacting_list_store
// Insertion-ordered key list with append, compacting remove and lookup.
// ----------------------------------------------------------------------------
// Each request passes a compare state, then a commit state. After start is
// taken, busy is high in the compare state while every slot compares its key
// with the request key, and in the following commit cycle the slots append,
// shift down or stay, with busy low so the next request can be taken in that
// cycle. The result word appears with out_valid for exactly one cycle right
// after the commit cycle, and the receiver cannot hold it off, so it must
// take it then. A new request can thus be taken while the previous one is
// still committing. An add to a full list is refused with full_reject set;
// opcode 3 does nothing and reports the count.
// ----------------------------------------------------------------------------
module compacting_list_store #(
  parameter int LIST_DEPTH = 16,
  parameter int KEY_WIDTH  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cls_pkg::cls_in_t  in_word,
  output logic              out_valid,
  output cls_pkg::cls_out_t out_word
);
  import cls_pkg::*;

  `include "compacting_list_store_defines.svh"

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  cls_state_t           state_r, state_nxt;
  logic [1:0]           op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  cls_out_t             out_word_r;
  logic                 accept;
  logic                 commit;
  logic                 full;
  logic                 any_match;
  logic                 hit;
  cls_ctrl_t            ctrl;

  logic [KEY_WIDTH-1:0] entry_vec [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] valid_vec;
  logic [LIST_DEPTH:0]   prefix_vec;

  assign accept = start & ~busy;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_CMP;
      ST_CMP:    state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = accept ? ST_CMP : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy   = 1'b0;
    commit = 1'b0;
    case (state_r)
      ST_CMP:    busy   = 1'b1;
      ST_COMMIT: commit = 1'b1;
      default: begin
        busy   = 1'b0;
        commit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture; the key is sized to the stored width.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_word.opcode;
      key_r <= KEY_WIDTH'(in_word.item_key);
    end
  end

  // Control broadcast to the slots.
  assign full        = (count_r == CNT_W'(LIST_DEPTH));
  assign any_match   = prefix_vec[LIST_DEPTH];
  assign ctrl.cmp_en = busy;
  assign ctrl.add_en = commit & (op_r == OP_ADD) & ~full;
  assign ctrl.rm_en  = commit & (op_r == OP_REMOVE);

  // Slot chain: slot 0 is the list head, data moves toward it on a remove.
  assign prefix_vec[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] up_entry;
    logic                 up_valid;
    logic                 low_valid;

    if (i == LIST_DEPTH - 1) begin : g_top
      assign up_entry = '0;
      assign up_valid = 1'b0;
    end else begin : g_mid
      assign up_entry = entry_vec[i+1];
      assign up_valid = valid_vec[i+1];
    end

    if (i == 0) begin : g_head
      assign low_valid = 1'b1;
    end else begin : g_body
      assign low_valid = valid_vec[i-1];
    end

    cls_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (key_r),
      .up_entry   (up_entry),
      .up_valid   (up_valid),
      .low_valid  (low_valid),
      .prefix_in  (prefix_vec[i]),
      .entry      (entry_vec[i]),
      .valid      (valid_vec[i]),
      .prefix_out (prefix_vec[i+1])
    );
  end

  // Hit flag and count update.
  always_comb begin
    hit       = 1'b0;
    count_nxt = count_r;
    case (op_r)
      OP_ADD: begin
        hit = ~full;
        if (!full) count_nxt = count_r + CNT_W'(1);
      end
      OP_REMOVE: begin
        hit = any_match;
        if (any_match) count_nxt = count_r - CNT_W'(1);
      end
      OP_TEST: hit = any_match;
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (commit) begin
      count_r <= count_nxt;
    end
  end

  // Registered result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= commit;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_word_r.hit         <= hit;
      out_word_r.full_reject <= (op_r == OP_ADD) & full;
      out_word_r.entry_count <= 5'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks on the slot chain and the sequencer.
  `CLS_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_W'(LIST_DEPTH), "count above depth")
  `CLS_ASSERT_IMP(a_valid_count, 1'b1, $countones(valid_vec) == 32'(count_r),
                  "slot valid bits disagree with count")
  `CLS_ASSERT_NXT(a_commit_result, commit, out_valid, "commit without result word")
  `CLS_ASSERT_IMP(a_flag_excl, out_valid, !(out_word.hit && out_word.full_reject),
                  "hit and full_reject both set")

endmodule

[sv/cls_cell.sv]
// ----------------------------------------------------------------------------
// cls_cell
// One list slot: holds a key and its valid bit, compares against the
// broadcast key, appends when it is the first free slot, and takes its upper
// neighbor's contents when a remove closes a gap at or below it.
// ----------------------------------------------------------------------------
module cls_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cls_pkg::cls_ctrl_t   ctrl,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [KEY_WIDTH-1:0] up_entry,
  input  logic                 up_valid,
  input  logic                 low_valid,
  input  logic                 prefix_in,
  output logic [KEY_WIDTH-1:0] entry,
  output logic                 valid,
  output logic                 prefix_out
);
  import cls_pkg::*;

  logic [KEY_WIDTH-1:0] entry_r;
  logic                 valid_r;
  logic                 valid_nxt;
  logic                 match_r;
  logic                 load_key;
  logic                 shift_down;

  // A match at or below this slot means the slot moves during a remove.
  assign prefix_out = prefix_in | match_r;
  assign shift_down = ctrl.rm_en & prefix_out;
  assign load_key   = ctrl.add_en & ~valid_r & low_valid;

  // Compare stage result, only for held entries.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match_r <= valid_r & (entry_r == key);
    end
  end

  // Key storage.
  always_ff @(posedge clk) begin
    if (shift_down) begin
      entry_r <= up_entry;
    end else if (load_key) begin
      entry_r <= key;
    end
  end

  // Valid bit follows the same moves as the key.
  always_comb begin
    valid_nxt = valid_r;
    if (shift_down) begin
      valid_nxt = up_valid;
    end else if (load_key) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the compacting list store.
// ----------------------------------------------------------------------------
// Each request word goes in through the start/busy handshake. The bench
// updates its own copy of the key list and queues the reply word that the
// request should produce. Every reply word that the block strobes out is
// compared with the oldest queued reply. A short directed table covers the
// empty list, the full list, duplicate keys, absent keys and the unused
// opcode. A long random run follows, alternating fill-heavy and drain-heavy
// stretches, with random idle bursts on the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import cls_pkg::*;

  localparam int          LIST_DEPTH  = 16;
  localparam int          RAND_ITEMS  = 1525;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  OPC_NOP     = 2'd3;

  // One row of the directed table; want is used only where known is set.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic        known;
    cls_out_t    want;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cls_in_t  in_word;
  logic     out_valid;
  cls_out_t out_word;

  // Bench copy of the list and the replies still owed by the block.
  logic [31:0] held_keys [LIST_DEPTH];
  int          held_count;
  cls_out_t    pending_replies [$];
  dir_row_t    dir_rows [$];
  int          mismatch_count;
  int          reply_index;
  int          cycle_count;

  compacting_list_store #(
    .LIST_DEPTH (LIST_DEPTH),
    .KEY_WIDTH  (32)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one request to the bench list and returns the reply it earns.
  function automatic cls_out_t apply_request(logic [1:0] op, logic [31:0] key);
    cls_out_t reply;
    int       match_pos;
    reply     = '0;
    match_pos = -1;
    for (int i = 0; i < held_count; i++) begin
      if (match_pos < 0 && held_keys[i] == key) begin
        match_pos = i;
      end
    end
    case (op)
      OP_ADD: begin
        if (held_count >= LIST_DEPTH) begin
          reply.full_reject = 1'b1;
        end else begin
          held_keys[held_count] = key;
          held_count++;
          reply.hit = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (match_pos >= 0) begin
          for (int i = match_pos; i + 1 < held_count; i++) begin
            held_keys[i] = held_keys[i + 1];
          end
          held_count--;
          reply.hit = 1'b1;
        end
      end
      OP_TEST: begin
        reply.hit = (match_pos >= 0);
      end
      default: begin
      end
    endcase
    reply.entry_count = held_count[4:0];
    return reply;
  endfunction

  // Drives one request word and holds it until the block takes it.
  task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                              input logic known, input cls_out_t want);
    cls_out_t predicted;
    start   <= 1'b1;
    in_word <= {op, key};
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_request(op, key);
    pending_replies.push_back(known ? want : predicted);
  endtask

  // Request side idles with noise on the word lines.
  task automatic idle_cycles(input int n);
    start   <= 1'b0;
    in_word <= {2'($urandom_range(0, 3)), $urandom};
    repeat (n) @(posedge clk);
  endtask

  // Waits until every owed reply has come back.
  task automatic drain_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(logic [1:0] op, logic [31:0] key, logic known,
                                  logic hit, logic full, logic [4:0] count);
    dir_row_t row;
    row.op   = op;
    row.key  = key;
    row.known = known;
    row.want = '{hit: hit, full_reject: full, entry_count: count};
    dir_rows.push_back(row);
  endfunction

  // Reply checker: each strobed word is compared with the oldest owed reply.
  always @(posedge clk) begin
    cls_out_t owed;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("reply %0d: unexpected word hit=%0b full=%0b count=%0d",
                   reply_index, out_word.hit, out_word.full_reject,
                   out_word.entry_count);
        end
      end else begin
        owed = pending_replies.pop_front();
        if (out_word.hit !== owed.hit || out_word.full_reject !== owed.full_reject ||
            out_word.entry_count !== owed.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("reply %0d: expected hit=%0b full=%0b count=%0d, got hit=%0b full=%0b count=%0d",
                     reply_index, owed.hit, owed.full_reject, owed.entry_count,
                     out_word.hit, out_word.full_reject, out_word.entry_count);
          end
        end
      end
      reply_index++;
    end
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [1:0]  op_sel;
    logic [31:0] key_sel;
    int          pick;
    logic        idle_on;
    logic        fill_phase;
    cycle_count    = 0;
    mismatch_count = 0;
    reply_index    = 0;
    held_count     = 0;
    idle_on        = 1'b0;
    fill_phase     = 1'b1;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_word <= '0;

    // Empty list, then two extreme keys and a duplicate.
    add_row(OP_TEST,   32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd0);
    add_row(OP_REMOVE, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd0);
    add_row(OPC_NOP,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 5'd0);
    add_row(OP_ADD,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd1);
    add_row(OP_ADD,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 5'd2);
    add_row(OP_TEST,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 5'd2);
    add_row(OP_ADD,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd3);
    add_row(OP_ADD,    32'h5555_5555, 1'b0, 1'b0, 1'b0, 5'd0);
    add_row(OP_ADD,    32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 5'd0);
    // Fill the list to the brim with walking-one keys.
    for (int k = 0; k < 11; k++) begin
      add_row(OP_ADD, 32'h0000_0001 << (3 * k), 1'b0, 1'b0, 1'b0, 5'd0);
    end
    // Add and no-op on a full list.
    add_row(OP_ADD,    32'h1234_5678, 1'b1, 1'b0, 1'b1, 5'd16);
    add_row(OPC_NOP,   32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd16);
    // Remove the first of two duplicates; the second must still be found.
    add_row(OP_REMOVE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd15);
    add_row(OP_TEST,   32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd15);
    add_row(OP_REMOVE, 32'hDEAD_BEEF, 1'b1, 1'b0, 1'b0, 5'd15);
    add_row(OP_REMOVE, 32'h4000_0000, 1'b0, 1'b0, 1'b0, 5'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      send_request(dir_rows[r].op, dir_rows[r].key, dir_rows[r].known,
                   dir_rows[r].want);
    end
    drain_replies();

    // Random part: fill-heavy and drain-heavy stretches in turn.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 100 == 0) begin
        idle_on    = ($urandom_range(0, 2) != 0);
        fill_phase = ~fill_phase;
      end
      pick = $urandom_range(0, 99);
      if (fill_phase) begin
        op_sel = (pick < 60) ? OP_ADD : (pick < 82) ? OP_REMOVE :
                 (pick < 96) ? OP_TEST : OPC_NOP;
      end else begin
        op_sel = (pick < 22) ? OP_ADD : (pick < 78) ? OP_REMOVE :
                 (pick < 95) ? OP_TEST : OPC_NOP;
      end
      // Keys mostly hit the list; a small pool makes duplicates common.
      pick = $urandom_range(0, 99);
      if (held_count > 0 && pick < 55) begin
        key_sel = held_keys[$urandom_range(0, held_count - 1)];
      end else if (pick < 80) begin
        key_sel = $urandom_range(0, 7);
      end else begin
        key_sel = $urandom;
      end
      send_request(op_sel, key_sel, 1'b0, '0);
      if (k == RAND_ITEMS / 2) begin
        drain_replies();
      end
      if (idle_on && k < RAND_ITEMS - 200 && $urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 13));
      end
    end

    // Let the last replies come back, then a few quiet cycles.
    drain_replies();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/cls_pkg.sv
sv/cls_cell.sv
sv/compacting_list_store.sv
tb/tb.sv
